[rtl/assert_macros.svh]
// assertion macros used by the checker file spr_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is high
`define SPR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// concurrent check that also runs through reset
`define SPR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

[rtl/spr_pkg.sv]
// shared widths, types and register codes of the steering rate limiter
// no dependencies
`timescale 1ns / 1ps

package spr_pkg;

   localparam int ANGLE_WIDTH    = 32;
   localparam int RATIO_WIDTH    = 32;
   localparam int DT_WIDTH       = 32;
   localparam int RATE_WIDTH     = 31;
   localparam int LIMIT_WIDTH    = 32;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = (ANGLE_WIDTH > 32) ? ANGLE_WIDTH : 32;
   // intermediate angles before the final saturation
   localparam int WIDE_WIDTH     = (ANGLE_WIDTH > 32) ? ANGLE_WIDTH + 8 : 40;
   // ratio numerator is |angle| scaled by 2^16
   localparam int NUM_WIDTH      = ANGLE_WIDTH + 16;
   localparam int DIV_RADIX      = 4;
   localparam int DIV_STAGES     = (NUM_WIDTH + DIV_RADIX - 1) / DIV_RADIX;

   localparam logic signed [RATIO_WIDTH-1:0] RATIO_ONE = RATIO_WIDTH'(32'sh0001_0000);
   localparam logic signed [RATIO_WIDTH-1:0] RATIO_MAX = RATIO_WIDTH'(32'sh7fff_ffff);
   localparam logic signed [RATIO_WIDTH-1:0] RATIO_MIN = RATIO_WIDTH'(32'sh8000_0000);

   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;
   typedef logic        [WIDE_WIDTH-1:0]  uwide_type;
   typedef logic        [DT_WIDTH-1:0]    dt_type;
   typedef logic        [RATE_WIDTH-1:0]  rate_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_POS_MIN = 3'd0,
      CSR_POS_MAX = 3'd1,
      CSR_VEL_MIN = 3'd2,
      CSR_VEL_MAX = 3'd3,
      CSR_ACC_MIN = 3'd4,
      CSR_ACC_MAX = 3'd5,
      CSR_DEC_MIN = 3'd6,
      CSR_DEC_MAX = 3'd7
   } csr_index_type;

   typedef struct packed {
      angle_type          pos_min;
      angle_type          pos_max;
      rate_type           vel_min;
      logic signed [31:0] vel_max;
      rate_type           acc_min;
      logic signed [31:0] acc_max;
      rate_type           dec_min;
      logic signed [31:0] dec_max;
   } csr_cfg_type;

   // limited angle with its command, from the limit pipe to the ratio pipe
   typedef struct packed {
      angle_type cmd;
      angle_type angle;
   } lim_word_type;

   typedef struct packed {
      angle_type                     limited_angle;
      logic signed [RATIO_WIDTH-1:0] scale_ratio;
   } rsp_word_type;

endpackage

[rtl/spr_if.sv]
// channel interfaces of the steering rate limiter: request, response, register write
// depends on spr_pkg
`timescale 1ns / 1ps

interface spr_req_if import spr_pkg::*; ();
   logic      valid;
   logic      ready;
   angle_type commanded_angle;
   angle_type previous_angle;
   angle_type older_angle;
   dt_type    time_step;

   modport source (output valid, commanded_angle, previous_angle, older_angle, time_step,
                   input ready);
   modport sink   (input valid, commanded_angle, previous_angle, older_angle, time_step,
                   output ready);
endinterface

interface spr_rsp_if import spr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   angle_type                     limited_angle;
   logic signed [RATIO_WIDTH-1:0] scale_ratio;

   modport source (output valid, limited_angle, scale_ratio, input ready);
   modport sink   (input valid, limited_angle, scale_ratio, output ready);
endinterface

interface spr_csr_if import spr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/spr_csr.sv]
// limit registers written through the register channel
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_csr import spr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_valid,
   output logic                      wr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  wr_index,
   input  logic [CSR_DATA_WIDTH-1:0] wr_data,
   output csr_cfg_type               cfg
);

   csr_cfg_type cfg_ff, cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (csr_index_type'(wr_index))
            CSR_POS_MIN: cfg_in.pos_min = angle_type'(wr_data[ANGLE_WIDTH-1:0]);
            CSR_POS_MAX: cfg_in.pos_max = angle_type'(wr_data[ANGLE_WIDTH-1:0]);
            CSR_VEL_MIN: cfg_in.vel_min = wr_data[RATE_WIDTH-1:0];
            CSR_VEL_MAX: cfg_in.vel_max = $signed(wr_data[31:0]);
            CSR_ACC_MIN: cfg_in.acc_min = wr_data[RATE_WIDTH-1:0];
            CSR_ACC_MAX: cfg_in.acc_max = $signed(wr_data[31:0]);
            CSR_DEC_MIN: cfg_in.dec_min = wr_data[RATE_WIDTH-1:0];
            CSR_DEC_MAX: cfg_in.dec_max = $signed(wr_data[31:0]);
         endcase
      end
   end

   // reset leaves every limit stage off
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_min <= angle_type'(1);
         cfg_ff.pos_max <= '0;
         cfg_ff.vel_min <= '0;
         cfg_ff.vel_max <= -32'sd1;
         cfg_ff.acc_min <= '0;
         cfg_ff.acc_max <= -32'sd1;
         cfg_ff.dec_min <= '0;
         cfg_ff.dec_max <= -32'sd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/spr_limit.sv]
// seven stage pipe: acceleration, velocity and position limits on one angle word
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_limit import spr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  csr_cfg_type  cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  angle_type    cmd,
   input  angle_type    prev,
   input  angle_type    older,
   input  dt_type       dt,
   output logic         out_valid,
   input  logic         out_ready,
   output lim_word_type out_word
);

   typedef logic signed [ANGLE_WIDTH:0] diff_type;

   typedef struct packed {
      angle_type cmd;
      angle_type p0;
      dt_type    dt;
      diff_type  dv;
      diff_type  dp0;
   } st1_type;

   typedef struct packed {
      angle_type                 cmd;
      angle_type                 p0;
      wide_type                  d2;
      wide_type                  base;
      logic                      slow;
      logic [DT_WIDTH:0]         dt2;
      rate_type                  vlo;
      rate_type                  vhi;
   } st2_type;

   typedef struct packed {
      angle_type              cmd;
      angle_type              p0;
      wide_type               base;
      logic                   neg;
      uwide_type              ad2;
      logic [LIMIT_WIDTH-1:0] alo;
      logic [LIMIT_WIDTH-1:0] ahi;
      rate_type               vlo;
      rate_type               vhi;
   } st3_type;

   typedef struct packed {
      angle_type cmd;
      angle_type p0;
      wide_type  p;
      rate_type  vlo;
      rate_type  vhi;
   } st4_type;

   typedef struct packed {
      angle_type cmd;
      angle_type p0;
      wide_type  p;
      logic      neg;
      uwide_type ad;
      rate_type  vlo;
      rate_type  vhi;
   } st5_type;

   typedef struct packed {
      angle_type cmd;
      wide_type  p;
   } st6_type;

   // below lo gives lo, above hi gives hi
   function automatic uwide_type clamp_u(uwide_type v, uwide_type lo, uwide_type hi);
      uwide_type r;
      if (v < lo)      r = lo;
      else if (v > hi) r = hi;
      else             r = v;
      return r;
   endfunction

   st1_type      s1_ff, s1_in;
   st2_type      s2_ff, s2_in;
   st3_type      s3_ff, s3_in;
   st4_type      s4_ff, s4_in;
   st5_type      s5_ff, s5_in;
   st6_type      s6_ff, s6_in;
   lim_word_type s7_ff, s7_in;
   logic [6:0]   v_ff, v_in;
   logic [6:0]   en;

   logic [2*DT_WIDTH-1:0]             dt_sq;
   logic [RATE_WIDTH+DT_WIDTH-1:0]    vlo_prod, vhi_prod;
   logic [RATE_WIDTH+DT_WIDTH:0]      alo_prod, ahi_prod;
   diff_type                          adv2, adp2;
   rate_type                          lo_rate, hi_rate;
   uwide_type                         da;
   uwide_type                         step;
   wide_type                          d5;
   wide_type                          pc;
   wide_type                          pmin_w, pmax_w;
   logic                              use_dec;

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[6] = !v_ff[6] || out_ready;
      for (int k = 5; k >= 0; k--) en[k] = !v_ff[k] || en[k+1];
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[6];
   assign out_word  = s7_ff;

   always_comb begin
      v_in[0] = en[0] ? in_valid : v_ff[0];
      for (int k = 1; k < 7; k++) v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
   end

   // stage 1: first differences
   always_comb begin
      s1_in.cmd = cmd;
      s1_in.p0  = prev;
      s1_in.dt  = dt;
      s1_in.dv  = diff_type'(cmd) - diff_type'(prev);
      s1_in.dp0 = diff_type'(prev) - diff_type'(older);
   end

   // stage 2: second difference, slowing test, dt squared, velocity bounds
   always_comb begin
      adv2     = s1_ff.dv[ANGLE_WIDTH]  ? -s1_ff.dv  : s1_ff.dv;
      adp2     = s1_ff.dp0[ANGLE_WIDTH] ? -s1_ff.dp0 : s1_ff.dp0;
      dt_sq    = s1_ff.dt * s1_ff.dt;
      vlo_prod = cfg.vel_min * s1_ff.dt;
      vhi_prod = cfg.vel_max[RATE_WIDTH-1:0] * s1_ff.dt;
      s2_in.cmd  = s1_ff.cmd;
      s2_in.p0   = s1_ff.p0;
      s2_in.d2   = wide_type'(s1_ff.dv) - wide_type'(s1_ff.dp0);
      s2_in.base = wide_type'(s1_ff.p0) + wide_type'(s1_ff.dp0);
      s2_in.slow = $unsigned(adv2) < $unsigned(adp2);
      s2_in.dt2  = dt_sq[2*DT_WIDTH-1:DT_WIDTH-1];
      s2_in.vlo  = vlo_prod[RATE_WIDTH+DT_WIDTH-1:DT_WIDTH];
      s2_in.vhi  = vhi_prod[RATE_WIDTH+DT_WIDTH-1:DT_WIDTH];
   end

   // stage 3: acceleration or deceleration bounds
   always_comb begin
      use_dec  = s2_ff.slow && !cfg.dec_max[31];
      lo_rate  = use_dec ? cfg.dec_min : cfg.acc_min;
      hi_rate  = use_dec ? cfg.dec_max[RATE_WIDTH-1:0] : cfg.acc_max[RATE_WIDTH-1:0];
      alo_prod = lo_rate * s2_ff.dt2;
      ahi_prod = hi_rate * s2_ff.dt2;
      s3_in.cmd  = s2_ff.cmd;
      s3_in.p0   = s2_ff.p0;
      s3_in.base = s2_ff.base;
      s3_in.neg  = s2_ff.d2[WIDE_WIDTH-1];
      s3_in.ad2  = s2_ff.d2[WIDE_WIDTH-1] ? uwide_type'(-s2_ff.d2) : uwide_type'(s2_ff.d2);
      s3_in.alo  = alo_prod[RATE_WIDTH+DT_WIDTH:DT_WIDTH];
      s3_in.ahi  = ahi_prod[RATE_WIDTH+DT_WIDTH:DT_WIDTH];
      s3_in.vlo  = s2_ff.vlo;
      s3_in.vhi  = s2_ff.vhi;
   end

   // stage 4: acceleration clamp, or the command itself when acc_max is negative
   always_comb begin
      da = clamp_u(s3_ff.ad2, uwide_type'(s3_ff.alo), uwide_type'(s3_ff.ahi));
      s4_in.cmd = s3_ff.cmd;
      s4_in.p0  = s3_ff.p0;
      s4_in.vlo = s3_ff.vlo;
      s4_in.vhi = s3_ff.vhi;
      if (!cfg.acc_max[31]) begin
         s4_in.p = s3_ff.neg ? s3_ff.base - $signed(da) : s3_ff.base + $signed(da);
      end else begin
         s4_in.p = wide_type'(s3_ff.cmd);
      end
   end

   // stage 5: step against the previous angle
   always_comb begin
      d5 = s4_ff.p - wide_type'(s4_ff.p0);
      s5_in.cmd = s4_ff.cmd;
      s5_in.p0  = s4_ff.p0;
      s5_in.p   = s4_ff.p;
      s5_in.neg = d5[WIDE_WIDTH-1];
      s5_in.ad  = d5[WIDE_WIDTH-1] ? uwide_type'(-d5) : uwide_type'(d5);
      s5_in.vlo = s4_ff.vlo;
      s5_in.vhi = s4_ff.vhi;
   end

   // stage 6: velocity clamp, skipped when vel_max is negative
   always_comb begin
      step = clamp_u(s5_ff.ad, uwide_type'(s5_ff.vlo), uwide_type'(s5_ff.vhi));
      s6_in.cmd = s5_ff.cmd;
      if (!cfg.vel_max[31]) begin
         s6_in.p = s5_ff.neg ? wide_type'(s5_ff.p0) - $signed(step)
                             : wide_type'(s5_ff.p0) + $signed(step);
      end else begin
         s6_in.p = s5_ff.p;
      end
   end

   // stage 7: position clamp when pos_min is not above pos_max, then saturation to the angle range
   always_comb begin
      pmin_w = wide_type'(cfg.pos_min);
      pmax_w = wide_type'(cfg.pos_max);
      pc     = s6_ff.p;
      if (cfg.pos_min <= cfg.pos_max) begin
         if (pc < pmin_w)      pc = pmin_w;
         else if (pc > pmax_w) pc = pmax_w;
      end
      s7_in.cmd = s6_ff.cmd;
      if (pc > wide_type'({1'b0, {(ANGLE_WIDTH-1){1'b1}}}))
         s7_in.angle = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      else if (pc < wide_type'(angle_type'({1'b1, {(ANGLE_WIDTH-1){1'b0}}})))
         s7_in.angle = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      else
         s7_in.angle = pc[ANGLE_WIDTH-1:0];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en[0]) s1_ff <= s1_in;
      if (en[1]) s2_ff <= s2_in;
      if (en[2]) s3_ff <= s3_in;
      if (en[3]) s4_ff <= s4_in;
      if (en[4]) s5_ff <= s5_in;
      if (en[5]) s6_ff <= s6_in;
      if (en[6]) s7_ff <= s7_in;
   end

endmodule

[rtl/spr_ratio.sv]
// pipelined restoring divider for limited over commanded angle, with output register
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_ratio import spr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  lim_word_type in_word,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_word_type out_word
);

   localparam int NST = DIV_STAGES + 2;

   typedef struct packed {
      logic [NUM_WIDTH-1:0]   num;
      logic [ANGLE_WIDTH-1:0] rem;
      logic [NUM_WIDTH-1:0]   quo;
      logic [ANGLE_WIDTH-1:0] den;
      logic                   zero;
      logic                   neg;
      angle_type              angle;
   } div_type;

   // one restoring step: bring in the next numerator bit, subtract when it fits
   function automatic div_type div_step(div_type x);
      div_type                r;
      logic [ANGLE_WIDTH:0]   trial;
      r     = x;
      trial = {x.rem, x.num[NUM_WIDTH-1]};
      r.num = {x.num[NUM_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, x.den}) begin
         trial = trial - {1'b0, x.den};
         r.quo = {x.quo[NUM_WIDTH-2:0], 1'b1};
      end else begin
         r.quo = {x.quo[NUM_WIDTH-2:0], 1'b0};
      end
      r.rem = trial[ANGLE_WIDTH-1:0];
      return r;
   endfunction

   div_type            div_ff [DIV_STAGES+1];
   div_type            div_in [DIV_STAGES+1];
   rsp_word_type       out_ff, out_in;
   logic [NST-1:0]     v_ff, v_in;
   logic [NST-1:0]     en;
   div_type            fin;
   logic [ANGLE_WIDTH-1:0] abs_p;
   logic [ANGLE_WIDTH-1:0] abs_c;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || out_ready;
      for (int k = NST-2; k >= 0; k--) en[k] = !v_ff[k] || en[k+1];
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NST-1];
   assign out_word  = out_ff;

   always_comb begin
      v_in[0] = en[0] ? in_valid : v_ff[0];
      for (int k = 1; k < NST; k++) v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
   end

   // magnitudes, signs and the zero command test
   always_comb begin
      abs_p = in_word.angle[ANGLE_WIDTH-1] ? $unsigned(-in_word.angle) : $unsigned(in_word.angle);
      abs_c = in_word.cmd[ANGLE_WIDTH-1]   ? $unsigned(-in_word.cmd)   : $unsigned(in_word.cmd);
      div_in[0].num   = {abs_p, 16'b0};
      div_in[0].rem   = '0;
      div_in[0].quo   = '0;
      div_in[0].den   = abs_c;
      div_in[0].zero  = (in_word.cmd == '0);
      div_in[0].neg   = in_word.angle[ANGLE_WIDTH-1] != in_word.cmd[ANGLE_WIDTH-1];
      div_in[0].angle = in_word.angle;
      // divider stages, a few quotient bits each
      for (int s = 1; s <= DIV_STAGES; s++) begin
         div_in[s] = div_ff[s-1];
         for (int k = 0; k < DIV_RADIX; k++) begin
            if ((s-1)*DIV_RADIX + k < NUM_WIDTH) div_in[s] = div_step(div_in[s]);
         end
      end
   end

   // saturate the quotient to the ratio range, or unity for a zero command
   always_comb begin
      fin = div_ff[DIV_STAGES];
      out_in.limited_angle = fin.angle;
      if (fin.zero)
         out_in.scale_ratio = RATIO_ONE;
      else if (fin.neg)
         out_in.scale_ratio = (fin.quo > NUM_WIDTH'(33'h0_8000_0000)) ? RATIO_MIN
                                                                    : RATIO_WIDTH'(-fin.quo);
      else
         out_in.scale_ratio = (fin.quo > NUM_WIDTH'(33'h0_7fff_ffff)) ? RATIO_MAX
                                                                    : RATIO_WIDTH'(fin.quo);
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         if (en[s]) div_ff[s] <= div_in[s];
      end
      if (en[NST-1]) out_ff <= out_in;
   end

endmodule

[rtl/steering_position_rate_limiter.sv]
// Steering position rate limiter, top level.
// Channels: req_bus carries one word per step (commanded, previous and older angle in
// Q16.16, time step in Q0.32); rsp_bus returns one word per request (limited angle and
// limited/commanded ratio in Q16.16); csr_bus writes the eight limit registers, index
// 0 to 7 in the order pos_min, pos_max, vel_min, vel_max, acc_min, acc_max, dec_min,
// dec_max. The user must write registers only while no word is in flight; unenforced.
// Pipeline from request accept to response valid: seven limit stages, one prep stage,
// DIV_STAGES (12) divider stages of four quotient bits each, one output register.
// Throughput: one word per cycle while rsp_bus.ready is high, set by the fully
// pipelined limit and divider stages.
// Reset clears all valid bits and turns every limit stage off (pos_min above pos_max,
// negative vel_max, acc_max and dec_max).
// Receiver stall: each stage holds its word while the next one is full; empty stages
// keep filling, so req_bus.ready falls only once every stage holds a word.
// depends on spr_pkg, spr_if, spr_csr, spr_limit, spr_ratio
`timescale 1ns / 1ps

module steering_position_rate_limiter import spr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   spr_req_if.sink    req_bus,
   spr_rsp_if.source  rsp_bus,
   spr_csr_if.sink    csr_bus
);

   csr_cfg_type  cfg;
   lim_word_type lim_word;
   rsp_word_type rsp_word;
   logic         lim_valid;
   logic         lim_ready;

   // limit registers
   spr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   // acceleration, velocity and position limits
   spr_limit u_limit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .cmd       (req_bus.commanded_angle),
      .prev      (req_bus.previous_angle),
      .older     (req_bus.older_angle),
      .dt        (req_bus.time_step),
      .out_valid (lim_valid),
      .out_ready (lim_ready),
      .out_word  (lim_word)
   );

   // ratio divider and response register
   spr_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lim_valid),
      .in_ready  (lim_ready),
      .in_word   (lim_word),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_word  (rsp_word)
   );

   assign rsp_bus.limited_angle = rsp_word.limited_angle;
   assign rsp_bus.scale_ratio   = rsp_word.scale_ratio;

endmodule

[rtl/spr_checker.sv]
// port level checks of the steering rate limiter and their bind
// depends on spr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spr_checker import spr_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input angle_type                     limited_angle,
   input logic signed [RATIO_WIDTH-1:0] scale_ratio
);

   // a stalled response word holds
   `SPR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(limited_angle) && $stable(scale_ratio))

   // no response word right after reset
   `SPR_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // a zero angle gives either a zero ratio or unity for a zero command
   `SPR_ASSERT(a_zero_ratio, clock, reset, rsp_valid && limited_angle == '0 |-> scale_ratio == '0 || scale_ratio == RATIO_ONE)

   // a negative ratio needs a nonzero angle
   `SPR_ASSERT(a_neg_ratio, clock, reset, rsp_valid && scale_ratio < 0 |-> limited_angle != '0)

endmodule

bind steering_position_rate_limiter spr_checker u_spr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .limited_angle (rsp_bus.limited_angle),
   .scale_ratio   (rsp_bus.scale_ratio)
);
